/* sv/nss_pkg.sv */
// Shared types and constants for the NLSF spacing stabilizer.
// No dependencies; used by nss_ctrl, nss_datapath and the top level.
package nss_pkg;

   localparam int Q15_ONE  = 32768;
   localparam int ORDER_W  = 5;
   localparam int ORDER_RST = 16;

   typedef struct packed {
      logic [14:0] coef_value;
      logic [14:0] min_gap;
      logic [14:0] upper_gap;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic signed [15:0] stable_value;
      logic               out_last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_SCAN_TOP,
      ST_DECIDE,
      ST_RD_A,
      ST_RD_B,
      ST_CENTER,
      ST_WR_B,
      ST_SORT_INIT,
      ST_SORT_RV,
      ST_SORT_LV,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_FWD_R0,
      ST_FWD_0,
      ST_FWD,
      ST_TOP,
      ST_BWD_R,
      ST_BWD,
      ST_OUT_INIT,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_SCAN_LAST,
      OP_SCAN_TOP,
      OP_DECIDE,
      OP_RD_A,
      OP_RD_B,
      OP_CENTER,
      OP_WR_B,
      OP_SORT_INIT,
      OP_SORT_RV,
      OP_SORT_LV,
      OP_SORT_CMP,
      OP_SORT_PUT,
      OP_FWD_R0,
      OP_FWD_0,
      OP_FWD,
      OP_TOP,
      OP_BWD_R,
      OP_BWD,
      OP_OUT_INIT,
      OP_OUT_RD,
      OP_OUT_LD
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic load_end;
      logic mind_neg;
      logic sel_zero;
      logic sel_top;
      logic last_pass;
      logic n_one;
      logic idx_last;
      logic idx_zero;
      logic cmp_gt;
      logic t_one;
      logic out_free;
   } status_type;

endpackage

/* sv/nss_ctrl.sv */
// Sequencer for the stabilizer: load, repair passes, fallback, emit.
// Depends on nss_pkg; drives nss_datapath through cmd_type/status_type.
module nss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  nss_pkg::status_type status,
   output nss_pkg::cmd_type    cmd
);

   nss_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nss_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nss_pkg::ST_LOAD: begin
            if (req_valid && status.load_end) state_in = nss_pkg::ST_SCAN;
         end
         nss_pkg::ST_SCAN: begin
            if (status.idx_last) state_in = nss_pkg::ST_SCAN_LAST;
         end
         nss_pkg::ST_SCAN_LAST: state_in = nss_pkg::ST_SCAN_TOP;
         nss_pkg::ST_SCAN_TOP:  state_in = nss_pkg::ST_DECIDE;
         nss_pkg::ST_DECIDE: begin
            if (!status.mind_neg) begin
               state_in = nss_pkg::ST_OUT_RD;
            end else if (status.sel_zero || status.sel_top) begin
               state_in = status.last_pass ? nss_pkg::ST_SORT_INIT : nss_pkg::ST_SCAN;
            end else begin
               state_in = nss_pkg::ST_RD_A;
            end
         end
         nss_pkg::ST_RD_A:   state_in = nss_pkg::ST_RD_B;
         nss_pkg::ST_RD_B:   state_in = nss_pkg::ST_CENTER;
         nss_pkg::ST_CENTER: state_in = nss_pkg::ST_WR_B;
         nss_pkg::ST_WR_B: begin
            state_in = status.last_pass ? nss_pkg::ST_SORT_INIT : nss_pkg::ST_SCAN;
         end
         nss_pkg::ST_SORT_INIT: begin
            state_in = status.n_one ? nss_pkg::ST_FWD_R0 : nss_pkg::ST_SORT_RV;
         end
         nss_pkg::ST_SORT_RV: state_in = nss_pkg::ST_SORT_LV;
         nss_pkg::ST_SORT_LV: state_in = nss_pkg::ST_SORT_CMP;
         nss_pkg::ST_SORT_CMP: begin
            if (status.cmp_gt) begin
               if (status.t_one) state_in = nss_pkg::ST_SORT_PUT;
            end else begin
               state_in = status.idx_last ? nss_pkg::ST_FWD_R0 : nss_pkg::ST_SORT_RV;
            end
         end
         nss_pkg::ST_SORT_PUT: begin
            state_in = status.idx_last ? nss_pkg::ST_FWD_R0 : nss_pkg::ST_SORT_RV;
         end
         nss_pkg::ST_FWD_R0: state_in = nss_pkg::ST_FWD_0;
         nss_pkg::ST_FWD_0: begin
            state_in = status.n_one ? nss_pkg::ST_TOP : nss_pkg::ST_FWD;
         end
         nss_pkg::ST_FWD: begin
            if (status.idx_last) state_in = nss_pkg::ST_TOP;
         end
         nss_pkg::ST_TOP: begin
            state_in = status.n_one ? nss_pkg::ST_OUT_INIT : nss_pkg::ST_BWD_R;
         end
         nss_pkg::ST_BWD_R: state_in = nss_pkg::ST_BWD;
         nss_pkg::ST_BWD: begin
            if (status.idx_zero) state_in = nss_pkg::ST_OUT_INIT;
         end
         nss_pkg::ST_OUT_INIT: state_in = nss_pkg::ST_OUT_RD;
         nss_pkg::ST_OUT_RD:   state_in = nss_pkg::ST_OUT_LD;
         nss_pkg::ST_OUT_LD: begin
            if (status.out_free) begin
               state_in = status.idx_last ? nss_pkg::ST_LOAD : nss_pkg::ST_OUT_RD;
            end
         end
         default: state_in = nss_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = nss_pkg::OP_NONE;
      case (state_ff)
         nss_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = nss_pkg::OP_LOAD;
         end
         nss_pkg::ST_SCAN:      cmd.op = nss_pkg::OP_SCAN;
         nss_pkg::ST_SCAN_LAST: cmd.op = nss_pkg::OP_SCAN_LAST;
         nss_pkg::ST_SCAN_TOP:  cmd.op = nss_pkg::OP_SCAN_TOP;
         nss_pkg::ST_DECIDE:    cmd.op = nss_pkg::OP_DECIDE;
         nss_pkg::ST_RD_A:      cmd.op = nss_pkg::OP_RD_A;
         nss_pkg::ST_RD_B:      cmd.op = nss_pkg::OP_RD_B;
         nss_pkg::ST_CENTER:    cmd.op = nss_pkg::OP_CENTER;
         nss_pkg::ST_WR_B:      cmd.op = nss_pkg::OP_WR_B;
         nss_pkg::ST_SORT_INIT: cmd.op = nss_pkg::OP_SORT_INIT;
         nss_pkg::ST_SORT_RV:   cmd.op = nss_pkg::OP_SORT_RV;
         nss_pkg::ST_SORT_LV:   cmd.op = nss_pkg::OP_SORT_LV;
         nss_pkg::ST_SORT_CMP:  cmd.op = nss_pkg::OP_SORT_CMP;
         nss_pkg::ST_SORT_PUT:  cmd.op = nss_pkg::OP_SORT_PUT;
         nss_pkg::ST_FWD_R0:    cmd.op = nss_pkg::OP_FWD_R0;
         nss_pkg::ST_FWD_0:     cmd.op = nss_pkg::OP_FWD_0;
         nss_pkg::ST_FWD:       cmd.op = nss_pkg::OP_FWD;
         nss_pkg::ST_TOP:       cmd.op = nss_pkg::OP_TOP;
         nss_pkg::ST_BWD_R:     cmd.op = nss_pkg::OP_BWD_R;
         nss_pkg::ST_BWD:       cmd.op = nss_pkg::OP_BWD;
         nss_pkg::ST_OUT_INIT:  cmd.op = nss_pkg::OP_OUT_INIT;
         nss_pkg::ST_OUT_RD:    cmd.op = nss_pkg::OP_OUT_RD;
         nss_pkg::ST_OUT_LD:    cmd.op = nss_pkg::OP_OUT_LD;
         default:               cmd.op = nss_pkg::OP_NONE;
      endcase
   end

endmodule

/* sv/nss_datapath.sv */
// Stabilizer datapath: coefficient and gap memories, scan/repair arithmetic,
// fallback sort and clamps, output register. Depends on nss_pkg.
module nss_datapath #(
   parameter int MAX_ORDER  = 16,
   parameter int MAX_PASSES = 20,
   localparam int CW = $clog2(MAX_ORDER + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  nss_pkg::cmd_type    cmd,
   output nss_pkg::status_type status,
   input  nss_pkg::req_type    req_data,
   input  logic [CW-1:0]       eff_order,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output nss_pkg::rsp_type    rsp_data
);

   localparam int IW = $clog2(MAX_ORDER);
   localparam int PW = $clog2(MAX_PASSES + 1);
   localparam int DW = 20;
   localparam int SW = 24;

   // memories
   logic [15:0] c_mem [MAX_ORDER];
   logic [14:0] g_mem [MAX_ORDER];
   logic [IW-1:0] c_addr, g_addr, c_waddr, g_waddr;
   logic          c_we, g_we;
   logic [15:0]   c_wdata;
   logic [14:0]   g_wdata;
   logic signed [15:0] c_rd_ff;
   logic [14:0]        g_rd_ff;

   always_ff @(posedge clock) begin
      if (c_we) c_mem[c_waddr] <= c_wdata;
      if (g_we) g_mem[g_waddr] <= g_wdata;
      c_rd_ff <= $signed(c_mem[c_addr]);
      g_rd_ff <= g_mem[g_addr];
   end

   // registers
   logic [CW-1:0] cnt_ff, cnt_in, n_ff, n_in, idx_ff, idx_in, t_ff, t_in, sel_ff, sel_in;
   logic [PW-1:0] pass_ff, pass_in;
   logic          pend_ff, pend_in, rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] prev_ff, prev_in, ca_ff, ca_in, newa_ff, newa_in, v_ff, v_in;
   logic signed [DW-1:0] mind_ff, mind_in;
   logic [14:0] gsel_ff, gsel_in, ug_ff, ug_in;
   logic signed [SW-1:0] lopre_ff, lopre_in, pre_ff, pre_in, total_ff, total_in;
   nss_pkg::rsp_type rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pass_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff     <= n_in;
      idx_ff   <= idx_in;
      t_ff     <= t_in;
      sel_ff   <= sel_in;
      prev_ff  <= prev_in;
      ca_ff    <= ca_in;
      newa_ff  <= newa_in;
      v_ff     <= v_in;
      mind_ff  <= mind_in;
      gsel_ff  <= gsel_in;
      ug_ff    <= ug_in;
      lopre_ff <= lopre_in;
      pre_ff   <= pre_in;
      total_ff <= total_in;
      rsp_ff   <= rsp_in;
   end

   // scan arithmetic
   logic [CW-1:0] k_idx;
   logic signed [DW-1:0] c_x, prev_x, g_x, ug_x, d_scan, d_top;
   logic load_end;
   logic [SW-1:0] load_sum;

   assign k_idx  = idx_ff - 1'b1;
   assign c_x    = DW'(c_rd_ff);
   assign prev_x = DW'(prev_ff);
   assign g_x    = $signed(DW'(g_rd_ff));
   assign ug_x   = $signed(DW'(ug_ff));
   assign d_scan = (k_idx == '0) ? (c_x - g_x) : (c_x - prev_x - g_x);
   assign d_top  = $signed(DW'(nss_pkg::Q15_ONE)) - prev_x - ug_x;

   assign load_end = req_data.is_last ||
                     ((CW+1)'(cnt_ff) + (CW+1)'(1) >= (CW+1)'(eff_order));
   assign load_sum = ((cnt_ff == '0) ? '0 : total_ff) + SW'(req_data.min_gap)
                     + (load_end ? SW'(req_data.upper_gap) : SW'(0));

   // centre repair
   logic signed [16:0] s_sum, ceil_h;
   logic signed [SW-1:0] half_x, gsel_x, lo_x, hi_x, a_x, lim_x;
   logic [15:0] newa_w;

   assign s_sum  = 17'(ca_ff) + 17'(c_rd_ff);
   assign ceil_h = (s_sum >>> 1) + $signed({16'b0, s_sum[0]});
   assign half_x = $signed(SW'(gsel_ff >> 1));
   assign gsel_x = $signed(SW'(gsel_ff));
   assign lo_x   = lopre_ff + half_x;
   assign hi_x   = $signed(SW'(nss_pkg::Q15_ONE)) - total_ff + lopre_ff + gsel_x - half_x;
   assign a_x    = SW'(ceil_h);

   always_comb begin
      if (lo_x > hi_x) begin
         lim_x = (a_x > lo_x) ? lo_x : ((a_x < hi_x) ? hi_x : a_x);
      end else begin
         lim_x = (a_x > hi_x) ? hi_x : ((a_x < lo_x) ? lo_x : a_x);
      end
   end

   assign newa_w = lim_x[15:0] - 16'(gsel_ff >> 1);

   // fallback clamps
   logic signed [16:0] f_sum, top_t, bwd_t;
   logic signed [15:0] f_t, f_new;

   assign f_sum = 17'(prev_ff) + $signed({2'b0, g_rd_ff});
   assign f_t   = (f_sum > 17'sd32767) ? 16'sd32767 : f_sum[15:0];
   assign f_new = (c_rd_ff < f_t) ? f_t : c_rd_ff;
   assign top_t = $signed(17'(nss_pkg::Q15_ONE)) - $signed({2'b0, ug_ff});
   assign bwd_t = 17'(prev_ff) - $signed({2'b0, g_rd_ff});

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      t_in     = t_ff;
      sel_in   = sel_ff;
      pass_in  = pass_ff;
      pend_in  = pend_ff;
      prev_in  = prev_ff;
      ca_in    = ca_ff;
      newa_in  = newa_ff;
      v_in     = v_ff;
      mind_in  = mind_ff;
      gsel_in  = gsel_ff;
      ug_in    = ug_ff;
      lopre_in = lopre_ff;
      pre_in   = pre_ff;
      total_in = total_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      c_addr   = idx_ff[IW-1:0];
      g_addr   = idx_ff[IW-1:0];
      c_we     = 1'b0;
      c_waddr  = idx_ff[IW-1:0];
      c_wdata  = 16'(c_rd_ff);
      g_we     = 1'b0;
      g_waddr  = cnt_ff[IW-1:0];
      g_wdata  = req_data.min_gap;

      // pending scan element, handled in the cycle after its read
      if (pend_ff) begin
         if (k_idx == '0 || d_scan < mind_ff) begin
            mind_in  = d_scan;
            sel_in   = k_idx;
            gsel_in  = g_rd_ff;
            lopre_in = pre_ff;
         end
         pre_in  = pre_ff + SW'(g_rd_ff);
         prev_in = c_rd_ff;
      end

      case (cmd.op)
         nss_pkg::OP_LOAD: begin
            c_we     = 1'b1;
            c_waddr  = cnt_ff[IW-1:0];
            c_wdata  = {1'b0, req_data.coef_value};
            g_we     = 1'b1;
            total_in = load_sum;
            if (load_end) begin
               n_in    = cnt_ff + 1'b1;
               ug_in   = req_data.upper_gap;
               cnt_in  = '0;
               idx_in  = '0;
               pass_in = '0;
               pend_in = 1'b0;
               pre_in  = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         nss_pkg::OP_SCAN: begin
            idx_in  = idx_ff + 1'b1;
            pend_in = 1'b1;
         end
         nss_pkg::OP_SCAN_LAST: pend_in = 1'b0;
         nss_pkg::OP_SCAN_TOP: begin
            if (d_top < mind_ff) begin
               mind_in  = d_top;
               sel_in   = n_ff;
               gsel_in  = ug_ff;
               lopre_in = pre_ff;
            end
         end
         nss_pkg::OP_DECIDE: begin
            idx_in  = '0;
            pre_in  = '0;
            pend_in = 1'b0;
            if (mind_ff[DW-1] && sel_ff == '0) begin
               c_we    = 1'b1;
               c_waddr = '0;
               c_wdata = {1'b0, gsel_ff};
               pass_in = pass_ff + 1'b1;
            end else if (mind_ff[DW-1] && sel_ff == n_ff) begin
               c_we    = 1'b1;
               c_waddr = IW'(n_ff - 1'b1);
               c_wdata = top_t[15:0];
               pass_in = pass_ff + 1'b1;
            end
         end
         nss_pkg::OP_RD_A: c_addr = IW'(sel_ff - 1'b1);
         nss_pkg::OP_RD_B: begin
            c_addr = sel_ff[IW-1:0];
            ca_in  = c_rd_ff;
         end
         nss_pkg::OP_CENTER: begin
            c_we    = 1'b1;
            c_waddr = IW'(sel_ff - 1'b1);
            c_wdata = newa_w;
            newa_in = $signed(newa_w);
         end
         nss_pkg::OP_WR_B: begin
            c_we    = 1'b1;
            c_waddr = sel_ff[IW-1:0];
            c_wdata = 16'(newa_ff) + {1'b0, gsel_ff};
            pass_in = pass_ff + 1'b1;
            idx_in  = '0;
            pre_in  = '0;
            pend_in = 1'b0;
         end
         nss_pkg::OP_SORT_INIT: idx_in = CW'(1);
         nss_pkg::OP_SORT_RV: c_addr = idx_ff[IW-1:0];
         nss_pkg::OP_SORT_LV: begin
            v_in   = c_rd_ff;
            t_in   = idx_ff;
            c_addr = IW'(idx_ff - 1'b1);
         end
         nss_pkg::OP_SORT_CMP: begin
            c_we    = 1'b1;
            c_waddr = t_ff[IW-1:0];
            if (c_rd_ff > v_ff) begin
               c_wdata = 16'(c_rd_ff);
               t_in    = t_ff - 1'b1;
               c_addr  = IW'(t_ff - CW'(2));
            end else begin
               c_wdata = 16'(v_ff);
               idx_in  = idx_ff + 1'b1;
            end
         end
         nss_pkg::OP_SORT_PUT: begin
            c_we    = 1'b1;
            c_waddr = '0;
            c_wdata = 16'(v_ff);
            idx_in  = idx_ff + 1'b1;
         end
         nss_pkg::OP_FWD_R0: begin
            c_addr = '0;
            g_addr = '0;
         end
         nss_pkg::OP_FWD_0: begin
            c_we    = 1'b1;
            c_waddr = '0;
            if (c_rd_ff < $signed({1'b0, g_rd_ff})) begin
               c_wdata = {1'b0, g_rd_ff};
               prev_in = $signed({1'b0, g_rd_ff});
            end else begin
               prev_in = c_rd_ff;
            end
            idx_in = CW'(1);
            c_addr = IW'(1);
            g_addr = IW'(1);
         end
         nss_pkg::OP_FWD: begin
            c_we    = 1'b1;
            c_waddr = idx_ff[IW-1:0];
            c_wdata = 16'(f_new);
            prev_in = f_new;
            idx_in  = idx_ff + 1'b1;
            c_addr  = IW'(idx_ff + 1'b1);
            g_addr  = IW'(idx_ff + 1'b1);
         end
         nss_pkg::OP_TOP: begin
            if (17'(prev_ff) > top_t) begin
               c_we    = 1'b1;
               c_waddr = IW'(n_ff - 1'b1);
               c_wdata = top_t[15:0];
               prev_in = $signed(top_t[15:0]);
            end
            idx_in = n_ff - CW'(2);
         end
         nss_pkg::OP_BWD_R: begin
            c_addr = idx_ff[IW-1:0];
            g_addr = IW'(idx_ff + 1'b1);
         end
         nss_pkg::OP_BWD: begin
            if (17'(c_rd_ff) > bwd_t) begin
               c_we    = 1'b1;
               c_waddr = idx_ff[IW-1:0];
               c_wdata = bwd_t[15:0];
               prev_in = $signed(bwd_t[15:0]);
            end else begin
               prev_in = c_rd_ff;
            end
            idx_in = idx_ff - 1'b1;
            c_addr = IW'(idx_ff - 1'b1);
            g_addr = idx_ff[IW-1:0];
         end
         nss_pkg::OP_OUT_INIT: idx_in = '0;
         nss_pkg::OP_OUT_RD: c_addr = idx_ff[IW-1:0];
         nss_pkg::OP_OUT_LD: begin
            if (out_free) begin
               rsp_in.stable_value = c_rd_ff;
               rsp_in.out_last     = status.idx_last;
               rsp_valid_in        = 1'b1;
               idx_in              = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      status.load_end  = load_end;
      status.mind_neg  = mind_ff[DW-1];
      status.sel_zero  = (sel_ff == '0);
      status.sel_top   = (sel_ff == n_ff);
      status.last_pass = (pass_ff == PW'(MAX_PASSES - 1));
      status.n_one     = (n_ff == CW'(1));
      status.idx_last  = ((CW+1)'(idx_ff) + (CW+1)'(1) == (CW+1)'(n_ff));
      status.idx_zero  = (idx_ff == '0);
      status.cmp_gt    = (c_rd_ff > v_ff);
      status.t_one     = (t_ff == CW'(1));
      status.out_free  = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/nss_spacing_stabilizer_top.sv */
// Top level of the NLSF spacing stabilizer: order register, controller, datapath.
// Depends on nss_pkg, nss_ctrl and nss_datapath.
//
// The block takes one Q15 coefficient per request, with the minimum gap
// below it; the request with is_last set (or the one that fills the
// configured order) also supplies the gap above the last coefficient and
// closes the vector. Each request is written into the memories as it is
// taken. Repair then runs out of two memories with one read and one write
// port each: each pass scans the vector with one coefficient read per
// cycle, and a centre repair adds the RD_A, RD_B, CENTER and WR_B steps,
// for up to MAX_PASSES passes. If the pass budget runs out, an insertion
// sort (one element move per cycle) and forward and backward clamp sweeps
// follow. Results leave through a registered output, each coefficient read
// and then loaded when the output register is free; the last one may sit in
// the output register while the next vector loads. The order register
// (csr_) is taken at any time but should only be written while idle; values
// outside 2..MAX_ORDER are saturated. No clearing pass after reset.
module nlsf_spacing_stabilizer_top #(
   parameter int MAX_ORDER  = 16,
   parameter int MAX_PASSES = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nss_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [nss_pkg::ORDER_W-1:0] csr_data
);

   localparam int CW = $clog2(MAX_ORDER + 1);

   // order register, saturated copy feeds the load counter compare
   logic [nss_pkg::ORDER_W-1:0] order_ff, order_in;
   logic [5:0]    order_x;
   logic [CW-1:0] eff_order;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= nss_pkg::ORDER_W'(nss_pkg::ORDER_RST);
      end else begin
         order_ff <= order_in;
      end
   end

   assign order_in  = csr_valid ? csr_data : order_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      order_x = 6'(order_ff);
      if (order_x < 6'd2) order_x = 6'd2;
      if (order_x > 6'(MAX_ORDER)) order_x = 6'(MAX_ORDER);
      eff_order = order_x[CW-1:0];
   end

   nss_pkg::cmd_type    cmd;
   nss_pkg::status_type status;

   nss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nss_datapath #(
      .MAX_ORDER  (MAX_ORDER),
      .MAX_PASSES (MAX_PASSES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .eff_order (eff_order),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/tb_nlsf_spacing_stabilizer_top.sv */
// Self-checking bench for nlsf_spacing_stabilizer_top: random and directed vectors,
// an in-bench predictor of the repair passes, and a scoreboard of expected coefficients.
// Depends on nss_pkg and the top level of the block.
`timescale 1ns / 1ps

class nlsf_scoreboard;
   int coef[16];
   int gap[17];
   int loaded;
   int order_reg;
   nss_pkg::rsp_type want[$];
   int errors;

   function new();
      loaded = 0;
      order_reg = nss_pkg::ORDER_RST;
      errors = 0;
   endfunction

   function void set_order(logic [4:0] v);
      order_reg = v;
   endfunction

   function int eff_order();
      if (order_reg < 2) return 2;
      if (order_reg > 16) return 16;
      return order_reg;
   endfunction

   function int wrap16(int v);
      logic signed [15:0] t;
      t = v[15:0];
      return t;
   endfunction

   // SILK-style clamp: bounds may be swapped
   function int clamp_range(int a, int lo, int hi);
      if (lo > hi) return a > lo ? lo : (a < hi ? hi : a);
      return a > hi ? hi : (a < lo ? lo : a);
   endfunction

   function void repair(int n);
      int p, i, k, d, mind, sel, half, lo, hi, s, ctr, v, t;
      for (p = 0; p < 20; p++) begin
         mind = coef[0] - gap[0];
         sel = 0;
         for (i = 1; i < n; i++) begin
            d = coef[i] - (coef[i-1] + gap[i]);
            if (d < mind) begin
               mind = d;
               sel = i;
            end
         end
         d = nss_pkg::Q15_ONE - (coef[n-1] + gap[n]);
         if (d < mind) begin
            mind = d;
            sel = n;
         end
         if (mind >= 0) return;
         if (sel == 0) begin
            coef[0] = gap[0];
         end else if (sel == n) begin
            coef[n-1] = wrap16(nss_pkg::Q15_ONE - gap[n]);
         end else begin
            half = gap[sel] >>> 1;
            lo = 0;
            hi = nss_pkg::Q15_ONE;
            for (k = 0; k < sel; k++) lo += gap[k];
            lo += half;
            for (k = n; k > sel; k--) hi -= gap[k];
            hi -= half;
            s = coef[sel-1] + coef[sel];
            ctr = wrap16(clamp_range((s >>> 1) + (s & 1), lo, hi));
            coef[sel-1] = wrap16(ctr - half);
            coef[sel] = wrap16(coef[sel-1] + gap[sel]);
         end
      end
      // pass budget spent: sort, then clamp forward and backward
      for (i = 1; i < n; i++) begin
         v = coef[i];
         k = i - 1;
         while (k >= 0 && coef[k] > v) begin
            coef[k+1] = coef[k];
            k--;
         end
         coef[k+1] = v;
      end
      if (coef[0] < gap[0]) coef[0] = gap[0];
      for (i = 1; i < n; i++) begin
         t = coef[i-1] + gap[i];
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
         if (coef[i] < t) coef[i] = t;
      end
      t = nss_pkg::Q15_ONE - gap[n];
      if (coef[n-1] > t) coef[n-1] = wrap16(t);
      for (i = n - 2; i >= 0; i--) begin
         t = coef[i+1] - gap[i+1];
         if (coef[i] > t) coef[i] = wrap16(t);
      end
   endfunction

   function void note_request(nss_pkg::req_type r);
      int idx, n, i;
      nss_pkg::rsp_type e;
      idx = loaded;
      if (idx >= 16) idx = 15;
      coef[idx] = r.coef_value;
      gap[idx] = r.min_gap;
      loaded = idx + 1;
      if (!r.is_last && loaded < eff_order()) return;
      n = loaded;
      gap[n] = r.upper_gap;
      repair(n);
      for (i = 0; i < n; i++) begin
         e.stable_value = coef[i][15:0];
         e.out_last = (i == n - 1);
         want.push_back(e);
      end
      loaded = 0;
   endfunction

   function void check(nss_pkg::rsp_type r);
      nss_pkg::rsp_type e;
      if (want.size() == 0) begin
         $error("unexpected result: stable_value=%0d out_last=%0b", r.stable_value, r.out_last);
         errors++;
         return;
      end
      e = want.pop_front();
      if (r.stable_value !== e.stable_value) begin
         $error("stable_value: expected %0d, got %0d", e.stable_value, r.stable_value);
         errors++;
      end
      if (r.out_last !== e.out_last) begin
         $error("out_last: expected %0b, got %0b", e.out_last, r.out_last);
         errors++;
      end
   endfunction
endclass

module tb_nlsf_spacing_stabilizer_top;

   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   nss_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   nss_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [nss_pkg::ORDER_W-1:0] csr_data = '0;

   nlsf_scoreboard coef_board = new();
   int cycles = 0;
   bit burst = 0;      // when set, the sender runs back to back

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   nlsf_spacing_stabilizer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Mostly short gaps, now and then a long one.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Hard timeout on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: check what was taken at this edge, then pick the next ready.
   // Stall stretches alternate with fully open stretches.
   int stall_left = 0;
   int open_left = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         coef_board.check(rsp_data);
      if (open_left > 0) begin
         open_left <= open_left - 1;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
         open_left <= $urandom_range(10, 60);
         rsp_ready <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_ready <= 1'b1;
      end
   end

   // One request; valid stays up into the next request when no gap is drawn.
   task automatic send_request(nss_pkg::req_type r);
      int g;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      coef_board.note_request(r);
      g = burst ? 0 : pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Lower valid after the last request of a stretch, then wait for all results.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (coef_board.want.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_order(logic [4:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      coef_board.set_order(v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function nss_pkg::req_type make_item(int cv, int mg, int ug, bit last);
      nss_pkg::req_type r;
      r.coef_value = cv[14:0];
      r.min_gap = mg[14:0];
      r.upper_gap = ug[14:0];
      r.is_last = last;
      return r;
   endfunction

   // One vector. Styles: 0 well spaced, 1 well spaced with a nudged entry,
   // 2 tight gaps (repairs likely), 3 pure noise (often falls back to sorting).
   task automatic send_vector(int len, int style);
      int i, pos, g, cv, ug, bad;
      bit last;
      pos = $urandom_range(0, 3000);
      bad = $urandom_range(0, len - 1);
      for (i = 0; i < len; i++) begin
         case (style)
            0, 1: begin
               g = $urandom_range(0, 32768 / (len + 2));
               pos = pos + g + $urandom_range(0, 400);
               if (pos > 32767) pos = 32767;
               cv = pos;
               if (style == 1 && i == bad)
                  cv = $urandom_range(0, 32767);
            end
            2: begin
               g = $urandom_range(500, 32768 / (len + 1));
               pos = pos + $urandom_range(0, 2000);
               if (pos > 32767) pos = 32767;
               cv = pos;
            end
            default: begin
               g = $urandom_range(0, 32767);
               cv = $urandom_range(0, 32767);
            end
         endcase
         ug = (style == 3) ? $urandom_range(0, 32767) : $urandom_range(0, 1500);
         if (i == len - 1)
            last = (len == coef_board.eff_order()) ? $urandom_range(0, 1) : 1'b1;
         else
            last = 1'b0;
         send_request(make_item(cv, g, ug, last));
      end
   endtask

   int sent = 0;
   int len, style;
   logic [4:0] phase_order[8] = '{5'd2, 5'd0, 5'd31, 5'd1, 5'd10, 5'd16, 5'd17, 5'd5};

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vectors at the reset order of 16, each closed by is_last.
      // single coefficient, nothing to repair
      send_request(make_item(0, 0, 0, 1));
      // all-ones fields: impossible gaps, runs into the fallback
      send_request(make_item(32767, 32767, 0, 0));
      send_request(make_item(32767, 32767, 32767, 1));
      // zeros under a nonzero gap: first coefficient gets clamped
      send_request(make_item(0, 100, 0, 0));
      send_request(make_item(0, 0, 0, 0));
      send_request(make_item(0, 0, 0, 1));
      // top entry above the ceiling
      send_request(make_item(100, 10, 0, 0));
      send_request(make_item(32767, 10, 5, 1));
      // descending pair: centre repair
      send_request(make_item(9000, 50, 0, 0));
      send_request(make_item(8000, 300, 0, 0));
      send_request(make_item(4000, 300, 0, 0));
      send_request(make_item(20000, 300, 200, 1));
      // gaps that do not fit: crossed centre bounds, fallback sort
      send_request(make_item(30000, 20000, 0, 0));
      send_request(make_item(100, 20000, 0, 0));
      send_request(make_item(16000, 20000, 0, 0));
      send_request(make_item(200, 20000, 20000, 1));
      // zero upper gap, top entry just below the ceiling: nothing to repair
      send_request(make_item(30000, 0, 0, 0));
      send_request(make_item(32767, 0, 0, 1));
      sent = 18;

      // Sender holds off until every expected result is back.
      drain();

      // Random phases, one order setting each, extremes included.
      for (int p = 0; p < 9; p++) begin
         if (p < 8) write_order(phase_order[p]);
         else write_order($urandom_range(0, 31));
         for (int k = 0; k < 50; k++) begin
            burst = ($urandom_range(0, 5) == 0);
            style = $urandom_range(0, 9);
            style = (style < 4) ? 0 : (style < 6) ? 1 : (style < 8) ? 2 : 3;
            len = coef_board.eff_order();
            // mostly full vectors; some closed early by is_last
            if ($urandom_range(0, 3) == 0) len = $urandom_range(1, len);
            // keep long vectors rare
            if (len > 10 && $urandom_range(0, 2) != 0) len = $urandom_range(1, 10);
            send_vector(len, style);
            sent += len;
            if (sent >= 460 + p * 0) break;
         end
         burst = 0;
         // leave a partial vector loaded now and then across the order change
         if ($urandom_range(0, 2) == 0)
            send_request(make_item($urandom_range(0, 32767), $urandom_range(0, 32767),
                                   $urandom_range(0, 32767), 1'b0));
         drain();
         if (sent >= 460) break;
      end

      // Close any open vector so nothing is left half loaded.
      if (coef_board.loaded != 0) begin
         send_request(make_item(1000, 10, 10, 1));
         drain();
      end

      if (coef_board.errors == 0 && coef_board.want.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
